FILE: hdl/rsaoa_pkg.sv
// ============================================================================
// rsaoa_pkg - ring sensor angle-of-arrival shared definitions
// Constants, control/status bundles and the elaboration-time direction
// table generator used by the controller and datapath.
// ============================================================================
package rsaoa_pkg;

    // Sensor slots addressed by the 4-bit index
    localparam int SLOTS        = 16;
    localparam int IDX_W        = 4;
    localparam int READ_W       = 16;
    localparam int ACC_W        = 37;
    localparam int VEC_W        = 21;
    localparam int AZ_W         = 17;
    localparam int CORDIC_STEPS = 32;
    localparam int STEP_W       = 5;
    localparam int CW           = 32;

    // Rotation CORDIC gain for the direction table (Q30)
    localparam longint CORDIC_GAIN = 64'sd652032874;

    // Degrees*256 per full turn, and half of it for the negative x axis
    localparam logic signed [17:0]     DEG_TURN = 18'sd92160;
    localparam logic signed [AZ_W-1:0] DEG_HALF = 17'sd46080;

    // Arc tangent table, binary angle with 2^32 per turn
    localparam logic [CW-1:0] ARC_TABLE [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // Controller to datapath commands
    typedef struct packed {
        logic take;         // input item accepted this cycle
        logic sat_load;     // report vector from accumulators, clear them
        logic cordic_init;  // load vectoring CORDIC from reported vector
        logic cordic_step;  // one CORDIC iteration
        logic mult;         // scale angle to degrees*256
        logic out_load;     // load output register
    } rsaoa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic acc_done;     // last item of a measure frame is summed
        logic cordic_last;  // final CORDIC iteration in progress
    } rsaoa_sts_t;

    // Q1.15 {sin, cos} of a binary angle, used only at elaboration
    function automatic logic [31:0] rsaoa_dir_entry(input logic [CW-1:0] turn_in);
        logic [CW-1:0] turn;
        logic          flip;
        longint        x;
        longint        y;
        longint        z;
        longint        nx;
        longint        xs;
        longint        ys;
        longint        rc;
        longint        rs;
        turn = turn_in;
        flip = (turn >= 32'h4000_0000) && (turn < 32'hC000_0000);
        if (flip)
            turn = turn - 32'h8000_0000;
        x = CORDIC_GAIN;
        y = 64'sd0;
        z = longint'(signed'(turn));
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            xs = x >>> k;
            ys = y >>> k;
            if (z >= 0)
            begin
                nx = x - ys;
                y  = y + xs;
                z  = z - longint'(64'(ARC_TABLE[k]));
            end
            else
            begin
                nx = x + ys;
                y  = y - xs;
                z  = z + longint'(64'(ARC_TABLE[k]));
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        rc = (x + 64'sd16384) >>> 15;
        rs = (y + 64'sd16384) >>> 15;
        if (rc > 64'sd32767)  rc = 64'sd32767;
        if (rc < -64'sd32768) rc = -64'sd32768;
        if (rs > 64'sd32767)  rs = 64'sd32767;
        if (rs < -64'sd32768) rs = -64'sd32768;
        return {rs[15:0], rc[15:0]};
    endfunction

endpackage

FILE: hdl/ring_sensor_angle_of_arrival_top.sv
// ============================================================================
// ring_sensor_angle_of_arrival_top - ring array direction finder
// Per-sensor baselines, weighted vector sum and CORDIC azimuth per frame.
// ============================================================================
// Usage:
//   Input stream: one reading per item. tuser = 0 stores the reading as the
//   sensor's baseline, tuser = 1 measures it. tlast marks the last item of
//   a frame. Indexes at or above SENSOR_COUNT are ignored.
//   Output stream: one item per measure frame, issued for the measure item
//   with tlast set: azimuth in degrees*256, reported x/y vector, and a
//   zero-vector flag on tuser.
// Timing:
//   Within a frame one item is taken per cycle (3-stage multiply-accumulate).
//   After the closing measure item the input stalls while the accumulate
//   pipeline drains, the vector is reported and loaded, the vectoring CORDIC
//   runs its 32 iterations, and the angle is scaled and the result loaded.
//   A waiting result sits in the output register while the next frame is
//   taken; the new result and the input then hold until the old one is taken.
// Reset: baselines and accumulators clear to zero, no result pending.
// ============================================================================
module ring_sensor_angle_of_arrival_top
    import rsaoa_pkg::*;
#(
    parameter int SENSOR_COUNT = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [3:0] sensor_index, [19:4] adc_reading
    input  logic        s_axis_tuser,   // req_type
    input  logic        s_axis_tlast,   // frame_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [16:0] azimuth_deg, [37:17] vector_x,
                                        // [58:38] vector_y
    output logic        m_axis_tuser    // vector_zero
);

    rsaoa_cmd_t cmd;
    rsaoa_sts_t sts;

    // Sequencer
    rsaoa_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd),
        .sts           (sts)
    );

    // Datapath
    rsaoa_dp #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

FILE: hdl/rsaoa_ctrl.sv
// ============================================================================
// rsaoa_ctrl - frame sequencer
// Gates input acceptance, steps the datapath through reporting, the CORDIC
// and the angle scaling, and owns the output valid flag.
// ============================================================================
module rsaoa_ctrl
    import rsaoa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tuser,
    input  logic       s_axis_tlast,
    output logic       s_axis_tready,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output rsaoa_cmd_t cmd,
    input  rsaoa_sts_t sts
);

    typedef enum logic [6:0] {
        ST_ACCUM = 7'b0000001,
        ST_DRAIN = 7'b0000010,
        ST_SAT   = 7'b0000100,
        ST_INIT  = 7'b0001000,
        ST_ITER  = 7'b0010000,
        ST_MULT  = 7'b0100000,
        ST_PUSH  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   valid_reg;
    logic   valid_next;
    logic   out_free;
    logic   frame_end;

    assign s_axis_tready = (state_reg == ST_ACCUM);
    assign m_axis_tvalid = valid_reg;
    assign out_free      = !valid_reg || m_axis_tready;
    assign frame_end     = cmd.take && s_axis_tuser && s_axis_tlast;

    // Commands
    always_comb
    begin
        cmd             = '0;
        cmd.take        = (state_reg == ST_ACCUM) && s_axis_tvalid;
        cmd.sat_load    = (state_reg == ST_SAT);
        cmd.cordic_init = (state_reg == ST_INIT);
        cmd.cordic_step = (state_reg == ST_ITER);
        cmd.mult        = (state_reg == ST_MULT);
        cmd.out_load    = (state_reg == ST_PUSH) && out_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCUM: if (frame_end)        state_next = ST_DRAIN;
            ST_DRAIN: if (sts.acc_done)     state_next = ST_SAT;
            ST_SAT:                         state_next = ST_INIT;
            ST_INIT:                        state_next = ST_ITER;
            ST_ITER:  if (sts.cordic_last)  state_next = ST_MULT;
            ST_MULT:                        state_next = ST_PUSH;
            ST_PUSH:  if (out_free)         state_next = ST_ACCUM;
            default:                        state_next = ST_ACCUM;
        endcase
    end

    // Output valid: set on load, dropped when taken
    always_comb
    begin
        if (cmd.out_load)
            valid_next = 1'b1;
        else if (m_axis_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

FILE: hdl/rsaoa_dp.sv
// ============================================================================
// rsaoa_dp - angle-of-arrival datapath
// Baseline registers, three-stage weighted accumulate, vector reporting,
// iterative vectoring CORDIC, degree scaling and the output register.
// ============================================================================
module rsaoa_dp
    import rsaoa_pkg::*;
#(
    parameter int SENSOR_COUNT = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [23:0] s_axis_tdata,   // [3:0] sensor_index, [19:4] adc_reading
    input  logic        s_axis_tuser,   // req_type
    input  logic        s_axis_tlast,   // frame_last
    output logic [63:0] m_axis_tdata,   // [16:0] azimuth_deg, [37:17] vector_x,
                                        // [58:38] vector_y
    output logic        m_axis_tuser,   // vector_zero
    input  rsaoa_cmd_t  cmd,
    output rsaoa_sts_t  sts
);

    localparam logic [6:0] IDX_LIMIT = 7'(SENSOR_COUNT);
    localparam logic signed [21:0] SH_MAX = 22'sd1048575;
    localparam logic signed [21:0] SH_MIN = -22'sd1048576;
    localparam logic signed [49:0] ROUND_HALF = 50'sd2147483648;

    // Direction table, fixed at elaboration
    logic signed [15:0] cos_tab [SLOTS];
    logic signed [15:0] sin_tab [SLOTS];

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_dir
        localparam logic [63:0] TURN = (64'(i) << 32) / 64'(SENSOR_COUNT);
        localparam logic [31:0] CS   = (i < SENSOR_COUNT) ?
                                       rsaoa_dir_entry(TURN[31:0]) : 32'd0;
        assign cos_tab[i] = CS[15:0];
        assign sin_tab[i] = CS[31:16];
    end

    // Saturate a floor-shifted accumulator to the reported width
    function automatic logic signed [VEC_W-1:0] sat_vec(input logic signed [ACC_W-1:0] a);
        logic signed [21:0] sh;
        sh = a[ACC_W-1:15];
        if (sh > SH_MAX)
            return SH_MAX[VEC_W-1:0];
        else if (sh < SH_MIN)
            return SH_MIN[VEC_W-1:0];
        else
            return sh[VEC_W-1:0];
    endfunction

    logic [IDX_W-1:0]  in_idx;
    logic [READ_W-1:0] in_reading;
    logic [READ_W-1:0] base_rd;
    logic              idx_ok;
    logic              hit;

    logic [READ_W-1:0] base_reg [SLOTS];

    logic                     s1_hit_reg;
    logic                     s1_last_reg;
    logic [READ_W-1:0]        s1_diff_reg;
    logic signed [15:0]       s1_cos_reg;
    logic signed [15:0]       s1_sin_reg;
    logic                     s2_hit_reg;
    logic                     s2_last_reg;
    logic signed [32:0]       s2_px_reg;
    logic signed [32:0]       s2_py_reg;
    logic                     s3_last_reg;
    logic signed [ACC_W-1:0]  acc_x_reg;
    logic signed [ACC_W-1:0]  acc_y_reg;

    logic signed [VEC_W-1:0]  vx_reg;
    logic signed [VEC_W-1:0]  vy_reg;
    logic                     zero_reg;
    logic                     axis_reg;
    logic signed [CW-1:0]     cx_reg;
    logic signed [CW-1:0]     cy_reg;
    logic [CW-1:0]            cz_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [CW-1:0]     x0;
    logic signed [CW-1:0]     y0;
    logic signed [CW-1:0]     xs;
    logic signed [CW-1:0]     ys;
    logic signed [49:0]       prod_reg;
    logic signed [49:0]       round_sum;
    logic signed [AZ_W-1:0]   az_next;

    logic signed [AZ_W-1:0]   az_reg;
    logic signed [VEC_W-1:0]  ox_reg;
    logic signed [VEC_W-1:0]  oy_reg;
    logic                     oz_reg;

    // Input decode and baseline lookup
    assign in_idx     = s_axis_tdata[IDX_W-1:0];
    assign in_reading = s_axis_tdata[IDX_W+READ_W-1:IDX_W];
    assign base_rd    = base_reg[in_idx];
    assign idx_ok     = {3'b000, in_idx} < IDX_LIMIT;
    assign hit        = cmd.take && s_axis_tuser && idx_ok && (in_reading > base_rd);

    // Baseline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                base_reg[i] <= '0;
        end
        else if (cmd.take && !s_axis_tuser && idx_ok)
        begin
            base_reg[in_idx] <= in_reading;
        end
    end

    // Accumulate pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_hit_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_hit_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
            s3_last_reg <= 1'b0;
        end
        else
        begin
            s1_hit_reg  <= hit;
            s1_last_reg <= cmd.take && s_axis_tuser && s_axis_tlast;
            s2_hit_reg  <= s1_hit_reg;
            s2_last_reg <= s1_last_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // Difference and weights, then products
    always_ff @(posedge clk)
    begin
        s1_diff_reg <= in_reading - base_rd;
        s1_cos_reg  <= cos_tab[in_idx];
        s1_sin_reg  <= sin_tab[in_idx];
        s2_px_reg   <= signed'({1'b0, s1_diff_reg}) * s1_cos_reg;
        s2_py_reg   <= signed'({1'b0, s1_diff_reg}) * s1_sin_reg;
    end

    // Accumulators, cleared once the frame is reported
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else if (cmd.sat_load)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else if (s2_hit_reg)
        begin
            acc_x_reg <= acc_x_reg + ACC_W'(s2_px_reg);
            acc_y_reg <= acc_y_reg + ACC_W'(s2_py_reg);
        end
    end

    assign sts.acc_done    = s3_last_reg;
    assign sts.cordic_last = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    // Reported vector
    always_ff @(posedge clk)
    begin
        if (cmd.sat_load)
        begin
            vx_reg <= sat_vec(acc_x_reg);
            vy_reg <= sat_vec(acc_y_reg);
        end
    end

    // CORDIC start values: vector times 256
    assign x0 = {{3{vx_reg[VEC_W-1]}}, vx_reg, 8'h00};
    assign y0 = {{3{vy_reg[VEC_W-1]}}, vy_reg, 8'h00};
    assign xs = cx_reg >>> step_reg;
    assign ys = cy_reg >>> step_reg;

    // Vectoring CORDIC, one iteration per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.cordic_init)
        begin
            zero_reg <= (vx_reg == '0) && (vy_reg == '0);
            axis_reg <= (vy_reg == '0) && vx_reg[VEC_W-1];
            if (vx_reg[VEC_W-1])
            begin
                cx_reg <= -x0;
                cy_reg <= -y0;
                cz_reg <= 32'h8000_0000;
            end
            else
            begin
                cx_reg <= x0;
                cy_reg <= y0;
                cz_reg <= '0;
            end
        end
        else if (cmd.cordic_step)
        begin
            if (cy_reg > 0)
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + ARC_TABLE[step_reg];
            end
            else
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - ARC_TABLE[step_reg];
            end
        end
    end

    // Iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (cmd.cordic_init)
            step_reg <= '0;
        else if (cmd.cordic_step)
            step_reg <= step_reg + 1'b1;
    end

    // Angle to degrees*256
    always_ff @(posedge clk)
    begin
        if (cmd.mult)
            prod_reg <= signed'(cz_reg) * DEG_TURN;
    end

    // Round half up, special cases for zero vector and negative x axis
    assign round_sum = prod_reg + ROUND_HALF;

    always_comb
    begin
        if (zero_reg)
            az_next = '0;
        else if (axis_reg)
            az_next = DEG_HALF;
        else
            az_next = round_sum[48:32];
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            az_reg <= az_next;
            ox_reg <= vx_reg;
            oy_reg <= vy_reg;
            oz_reg <= zero_reg;
        end
    end

    assign m_axis_tdata = {5'b00000, oy_reg, ox_reg, az_reg};
    assign m_axis_tuser = oz_reg;

endmodule

FILE: verif/tb_ring_sensor_angle_of_arrival_top.sv
// ============================================================================
// tb_ring_sensor_angle_of_arrival_top - ring direction finder testbench
// Streams baseline and measure readings into the block and predicts every
// frame result (reported vector, zero flag and CORDIC azimuth) with a
// bit-exact model kept inside the bench. Results are compared in order,
// field by field. Both stream sides idle in random bursts, the receiver
// holds off once for a long stretch, and the sender now and then pauses
// until all results are back.
// ============================================================================
module tb_ring_sensor_angle_of_arrival_top;

    localparam int RING_N      = 16;
    localparam int ITEM_TARGET = 700;
    localparam int TAIL_ITEMS  = 60;      // no idling once this few are left
    localparam int LONG_HOLD   = 600;     // receiver hold-off, cycles
    localparam int HOLD_AT     = 300;     // items taken before the hold-off
    localparam int DRAIN_WAIT  = 60;      // extra wait after the last result is checked
    localparam int CYCLE_LIMIT = 400000;

    localparam bit KIND_BASE    = 1'b0;
    localparam bit KIND_MEASURE = 1'b1;

    localparam longint ROT_GAIN  = 64'sd652032874;
    localparam longint DEG_TURN  = 64'sd92160;
    localparam longint AZ_NEG_X  = 64'sd46080;
    localparam longint VEC_MAX   = 64'sd1048575;
    localparam longint VEC_MIN   = -64'sd1048576;

    // arc tangent of 2^-k, binary angle with 2^32 per turn
    localparam logic [31:0] ARC [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        bit          measure;
        logic [3:0]  idx;
        logic [15:0] rd;
        bit          last;
        bit          hold;     // sender waits for all results before this one
    } reading_t;

    typedef struct packed {
        logic signed [16:0] az;
        logic signed [20:0] vx;
        logic signed [20:0] vy;
        logic               zero;
    } bearing_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [3:0] sensor_index, [19:4] adc_reading
    logic        s_axis_tuser = 1'b0; // req_type
    logic        s_axis_tlast = 1'b0; // frame_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // [16:0] azimuth_deg, [37:17] vector_x,
                                      // [58:38] vector_y
    logic        m_axis_tuser;        // vector_zero

    reading_t reading_q[$];
    bearing_t bearing_q[$];

    // predictor state
    logic [15:0]        baseline [RING_N];
    logic signed [15:0] dir_cos [RING_N];
    logic signed [15:0] dir_sin [RING_N];
    logic signed [36:0] sum_x = '0;
    logic signed [36:0] sum_y = '0;

    int  cyc = 0;
    int  err_cnt = 0;
    int  taken_cnt = 0;
    bit  in_took = 1'b0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  tx_pct = 10;
    int  rx_pct = 10;
    bit  long_hold_done = 1'b0;
    bit  pause_next = 1'b0;

    bearing_t           want;
    logic signed [16:0] got_az;
    logic signed [20:0] got_vx;
    logic signed [20:0] got_vy;

    ring_sensor_angle_of_arrival_top #(.SENSOR_COUNT(RING_N)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Q1.15 cosine and sine of a binary angle by rotation CORDIC
    function automatic void unit_vector(input logic [31:0] ang,
                                        output logic signed [15:0] c,
                                        output logic signed [15:0] s);
        logic [31:0] a;
        bit          flip;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        longint      rc;
        longint      rs;
        a = ang;
        flip = (a >= 32'h4000_0000) && (a < 32'hC000_0000);
        if (flip)
            a = a - 32'h8000_0000;
        x = ROT_GAIN;
        y = 0;
        z = longint'($signed(a));
        for (int k = 0; k < 32; k++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> k);
                y  = y + (x >>> k);
                z  = z - longint'(ARC[k]);
            end
            else
            begin
                nx = x + (y >>> k);
                y  = y - (x >>> k);
                z  = z + longint'(ARC[k]);
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        rc = (x + 64'sd16384) >>> 15;
        rs = (y + 64'sd16384) >>> 15;
        rc = (rc > 32767) ? 32767 : ((rc < -32768) ? -32768 : rc);
        rs = (rs > 32767) ? 32767 : ((rs < -32768) ? -32768 : rs);
        c = rc[15:0];
        s = rs[15:0];
    endfunction

    // accumulator to reported component: floor by 2^15, saturate to 21 bits
    function automatic longint vector_report(input logic signed [36:0] acc);
        longint v;
        v = longint'(acc) >>> 15;
        if (v > VEC_MAX)
            v = VEC_MAX;
        if (v < VEC_MIN)
            v = VEC_MIN;
        return v;
    endfunction

    // azimuth in degrees*256 by vectoring CORDIC on the reported vector
    function automatic logic signed [16:0] azimuth_of_vector(input longint vx,
                                                             input longint vy);
        longint      x;
        longint      y;
        longint      nx;
        longint      t;
        logic [31:0] z;
        if (vx == 0 && vy == 0)
            return '0;
        if (vy == 0 && vx < 0)
            return AZ_NEG_X[16:0];
        x = vx * 256;
        y = vy * 256;
        z = '0;
        // left half plane: turn by half a turn first
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int k = 0; k < 32; k++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> k);
                y  = y - (x >>> k);
                z  = z + ARC[k];
            end
            else
            begin
                nx = x - (y >>> k);
                y  = y + (x >>> k);
                z  = z - ARC[k];
            end
            x = nx;
        end
        // scale to degrees*256, halves rounded up
        t = longint'($signed(z)) * DEG_TURN + 64'sd2147483648;
        t = t >>> 32;
        return t[16:0];
    endfunction

    // apply one accepted reading; a closing measure item yields a bearing
    task automatic predict_reading(input bit measure, input logic [3:0] idx,
                                   input logic [15:0] rd, input bit last);
        bearing_t b;
        longint   d;
        longint   vx;
        longint   vy;
        if (idx < RING_N)
        begin
            if (measure == KIND_BASE)
                baseline[idx] = rd;
            else if (rd > baseline[idx])
            begin
                d = longint'(rd) - longint'(baseline[idx]);
                sum_x = sum_x + 37'(d * dir_cos[idx]);
                sum_y = sum_y + 37'(d * dir_sin[idx]);
            end
        end
        if (measure == KIND_MEASURE && last)
        begin
            vx = vector_report(sum_x);
            vy = vector_report(sum_y);
            b.az   = azimuth_of_vector(vx, vy);
            b.vx   = vx[20:0];
            b.vy   = vy[20:0];
            b.zero = (vx == 0 && vy == 0);
            bearing_q.push_back(b);
            sum_x = '0;
            sum_y = '0;
        end
    endtask

    function automatic void queue_reading(input bit measure, input int idx,
                                          input int rd, input bit last);
        reading_t r;
        r.measure = measure;
        r.idx     = idx[3:0];
        r.rd      = rd[15:0];
        r.last    = last;
        r.hold    = pause_next;
        pause_next = 1'b0;
        reading_q.push_back(r);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    // input driver: changes on the falling edge
    always @(negedge clk)
    begin
        if (cyc[8:0] == 9'd0)
            tx_pct <= pick_pct();
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (s_axis_tvalid && !in_took)
            s_axis_tvalid <= 1'b1;
        else if (tx_gap > 0)
        begin
            tx_gap <= tx_gap - 1;
            s_axis_tvalid <= 1'b0;
        end
        else if (reading_q.size() == 0)
            s_axis_tvalid <= 1'b0;
        else if (reading_q[0].hold && bearing_q.size() != 0)
            s_axis_tvalid <= 1'b0;
        else if (reading_q.size() > TAIL_ITEMS && $urandom_range(0, 99) < tx_pct)
        begin
            tx_gap <= $urandom_range(0, 3);
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {4'b0, reading_q[0].rd, reading_q[0].idx};
            s_axis_tuser  <= reading_q[0].measure;
            s_axis_tlast  <= reading_q[0].last;
            void'(reading_q.pop_front());
        end
    end

    // result receiver: ready bursts plus one long hold-off
    always @(negedge clk)
    begin
        if (cyc[8:0] == 9'd256)
            rx_pct <= pick_pct();
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (rx_gap > 0)
        begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!long_hold_done && taken_cnt >= HOLD_AT)
        begin
            long_hold_done <= 1'b1;
            rx_gap <= LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end
        else if (reading_q.size() > TAIL_ITEMS && $urandom_range(0, 99) < rx_pct)
        begin
            rx_gap <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // handshakes at the rising edge: check results, predict from readings
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (!rst_n)
            in_took <= 1'b0;
        else
        begin
            in_took <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_az = m_axis_tdata[16:0];
                got_vx = m_axis_tdata[37:17];
                got_vy = m_axis_tdata[58:38];
                if (bearing_q.size() == 0)
                begin
                    $error("unexpected result: az %0d x %0d y %0d", got_az,
                           got_vx, got_vy);
                    err_cnt++;
                end
                else
                begin
                    want = bearing_q.pop_front();
                    if (got_az !== want.az)
                    begin
                        $error("azimuth_deg: expected %0d, got %0d", want.az, got_az);
                        err_cnt++;
                    end
                    if (got_vx !== want.vx)
                    begin
                        $error("vector_x: expected %0d, got %0d", want.vx, got_vx);
                        err_cnt++;
                    end
                    if (got_vy !== want.vy)
                    begin
                        $error("vector_y: expected %0d, got %0d", want.vy, got_vy);
                        err_cnt++;
                    end
                    if (m_axis_tuser !== want.zero)
                    begin
                        $error("vector_zero: expected %0d, got %0d", want.zero,
                               m_axis_tuser);
                        err_cnt++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                taken_cnt <= taken_cnt + 1;
                predict_reading(s_axis_tuser, s_axis_tdata[3:0],
                                s_axis_tdata[19:4], s_axis_tlast);
            end
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        if (cyc == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int n;
        int k;
        int len;
        for (int i = 0; i < RING_N; i++)
        begin
            baseline[i] = '0;
            unit_vector(32'(longint'(i) * 64'd4294967296 / RING_N),
                        dir_cos[i], dir_sin[i]);
        end

        // directed: single sensors on the axes, negative x axis, zero vector
        queue_reading(KIND_MEASURE, 0, 16'hFFFF, 1);
        queue_reading(KIND_MEASURE, 8, 16'hFFFF, 1);
        queue_reading(KIND_MEASURE, 4, 16'hFFFF, 1);
        queue_reading(KIND_MEASURE, 12, 1, 1);
        queue_reading(KIND_MEASURE, 3, 0, 1);
        // baseline item closing a frame gives no result
        queue_reading(KIND_BASE, 5, 16'hFFFF, 1);
        // readings at and below the baseline add nothing
        queue_reading(KIND_MEASURE, 5, 16'hFFFF, 0);
        queue_reading(KIND_MEASURE, 5, 12345, 1);
        queue_reading(KIND_BASE, 6, 16'h8000, 0);
        queue_reading(KIND_MEASURE, 6, 16'h8001, 0);
        queue_reading(KIND_MEASURE, 2, 16'hFFFF, 0);
        queue_reading(KIND_MEASURE, 10, 16'hFFFF, 1);
        queue_reading(KIND_BASE, 1, 16'hAAAA, 0);
        queue_reading(KIND_BASE, 1, 16'h0000, 1);
        queue_reading(KIND_MEASURE, 9, 16'h5555, 0);
        queue_reading(KIND_MEASURE, 7, 16'hFFFF, 0);
        queue_reading(KIND_MEASURE, 15, 16'h7FFF, 0);
        queue_reading(KIND_MEASURE, 11, 1, 1);

        // random part, mostly well-formed frames
        pause_next = 1'b1;
        n = reading_q.size();
        while (n < ITEM_TARGET)
        begin
            if (n >= 450 && n < 470)
                pause_next = 1'b1;
            k = $urandom_range(0, 99);
            if (k < 10)
            begin
                // noise
                queue_reading($urandom_range(0, 1), $urandom_range(0, 15),
                              $urandom_range(0, 65535), $urandom_range(0, 1));
                n++;
            end
            else if (k < 22)
            begin
                // baseline frame, mostly low levels
                len = $urandom_range(1, 16);
                for (int j = 0; j < len; j++)
                    queue_reading(KIND_BASE, $urandom_range(0, 15),
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 20000),
                                  j == len - 1);
                n += len;
            end
            else if (k < 25)
            begin
                // one sensor driven hard: saturates, and long runs wrap the sums
                len = $urandom_range(33, 90);
                k = $urandom_range(0, 15);
                queue_reading(KIND_BASE, k, 0, 0);
                for (int j = 0; j < len; j++)
                    queue_reading(KIND_MEASURE, k, $urandom_range(60000, 65535),
                                  j == len - 1);
                n += len + 1;
            end
            else if (k < 31)
            begin
                // measure readings with no frame end, carried into the next frame
                len = $urandom_range(1, 4);
                for (int j = 0; j < len; j++)
                    queue_reading(KIND_MEASURE, $urandom_range(0, 15),
                                  $urandom_range(0, 65535), 0);
                n += len;
            end
            else
            begin
                len = $urandom_range(1, 16);
                for (int j = 0; j < len; j++)
                    queue_reading(KIND_MEASURE, $urandom_range(0, 15),
                                  $urandom_range(0, 65535), j == len - 1);
                n += len;
            end
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // drain
        while (reading_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (bearing_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
hdl/rsaoa_pkg.sv
hdl/rsaoa_ctrl.sv
hdl/rsaoa_dp.sv
hdl/ring_sensor_angle_of_arrival_top.sv
verif/tb_ring_sensor_angle_of_arrival_top.sv
